// File: rtl/ras_pkg.sv
// Shared types, constants and key mapping for the row argsort core.
// No dependencies.
package ras_pkg;
    localparam int RowMaxDefault = 64;
    localparam int PosW = 6;
    localparam int ValW = 32;

    // Map float bits to an unsigned key under the total order; -0 folds onto +0.
    function automatic logic [ValW-1:0] order_key(input logic [ValW-1:0] bits);
        logic [ValW-1:0] b;
        b = (bits == 32'h8000_0000) ? 32'h0 : bits;
        if (b[31]) return ~b;
        return b | 32'h8000_0000;
    endfunction

    typedef struct packed {
        logic             vld;
        logic [ValW-1:0]  key;
        logic [PosW-1:0]  pos;
    } t_entry;

    typedef struct packed {
        logic load;   // new entry enters at the head
        logic shift;  // drain: every cell hands its entry toward the head
        logic clear;  // empty all cells
        logic desc;   // descending order
    } t_ctrl;
endpackage

// File: rtl/ras_cell.sv
// One sorter cell: holds one entry, ordered toward the tail in sort order.
// Depends on ras_pkg.
module ras_cell import ras_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctrl  i_ctrl,
    input  t_entry i_new,        // incoming entry, broadcast to every cell
    input  t_entry i_prev,       // entry held by the cell before
    input  logic   i_prev_keep,  // cell before holds its entry this load
    input  t_entry i_from_next,  // neighbor behind, used while draining
    output t_entry o_entry,
    output logic   o_keep        // this cell holds its entry this load
);
    t_entry r_ent, n_ent;
    logic   keep_mine;

    // Hold on a tie: the incoming entry has the larger index, so it goes
    // after equals. Key compare flips for descending.
    always_comb begin
        if (!r_ent.vld) keep_mine = 1'b0;
        else if (r_ent.key == i_new.key) keep_mine = 1'b1;
        else keep_mine = i_ctrl.desc ? (r_ent.key > i_new.key)
                                     : (r_ent.key < i_new.key);
    end

    // On load, a cell that gives way takes the new entry if the cell before
    // holds, else it takes the entry of the cell before.
    always_comb begin
        n_ent = r_ent;
        if (i_ctrl.clear) n_ent.vld = 1'b0;
        else if (i_ctrl.shift) n_ent = i_from_next;
        else if (i_ctrl.load && !keep_mine) n_ent = i_prev_keep ? i_new : i_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.vld <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end
    assign o_entry = r_ent;
    assign o_keep  = keep_mine;
endmodule

// File: rtl/row_argsort_core.sv
// Top level of the row argsort core: control and the chain of sorter cells.
// Depends on ras_pkg and ras_cell.
//
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+--------------------------
// input     | i_value_bits, i_row_end                 | start & !busy
// result    | o_position, o_last_rank, o_overflow     | o_strobe, one cycle each
// config    | i_sort_order                            | i_cfg_we
//
// A value without row end is broadcast to every cell, each compares
// against it in parallel, and the cells behind the insert point shift one
// place toward the tail. On row end, that value is inserted, then N results,
// one per cycle, are shifted out of the chain head; busy is high through the
// drain.
// Reset clears all cell valid bits, the count and the overflow flag.
// The receiver cannot stall; results are strobed and never held.
module row_argsort_core import ras_pkg::*; #(
    parameter int RowMax = RowMaxDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [31:0]     i_value_bits,
    input  logic            i_row_end,
    input  logic            i_cfg_we,
    input  logic            i_sort_order,
    output logic            o_strobe,
    output logic [PosW-1:0] o_position,
    output logic            o_last_rank,
    output logic            o_overflow
);
    localparam int CntW = $clog2(RowMax + 1);

    t_entry cell_q    [RowMax];
    t_entry prev_ent  [RowMax];
    logic   keep      [RowMax];
    logic   prev_keep [RowMax];
    t_entry nxt       [RowMax+1];
    t_entry new_ent;
    t_ctrl  ctrl;

    logic            r_desc;
    logic [CntW-1:0] r_count, n_count;
    logic            r_ovf, r_drain, r_ovf_out;
    logic [CntW-1:0] r_left;
    logic            accept, stored;

    assign busy   = r_drain;
    assign accept = start && !busy;
    assign stored = accept && (r_count < CntW'(RowMax));

    always_comb begin
        ctrl.load  = stored;
        ctrl.shift = r_drain;
        ctrl.clear = 1'b0;
        ctrl.desc  = r_desc;
    end

    // Every cell sees the new entry; the tail drains an empty entry.
    always_comb begin
        new_ent.vld = stored;
        new_ent.key = order_key(i_value_bits);
        new_ent.pos = PosW'(r_count);
        nxt[RowMax] = '0;
    end

    genvar g;
    generate
        for (g = 0; g < RowMax; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign prev_ent[g]  = '0;
                assign prev_keep[g] = 1'b1;
            end else begin : g_body
                assign prev_ent[g]  = cell_q[g-1];
                assign prev_keep[g] = keep[g-1];
            end
            ras_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (ctrl),
                .i_new      (new_ent),
                .i_prev     (prev_ent[g]),
                .i_prev_keep(prev_keep[g]),
                .i_from_next(nxt[g+1]),
                .o_entry    (cell_q[g]),
                .o_keep     (keep[g])
            );
            assign nxt[g] = cell_q[g];
        end
    endgenerate

    assign n_count = stored ? r_count + 1'b1 : r_count;

    // Config latches any time; hold sort direction for the drain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc    <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_drain   <= 1'b0;
            r_left    <= '0;
            r_ovf_out <= 1'b0;
        end else begin
            if (i_cfg_we) r_desc <= i_sort_order;
            if (r_drain) begin
                r_left <= r_left - 1'b1;
                if (r_left == CntW'(1)) r_drain <= 1'b0;
            end else if (accept) begin
                if (i_row_end) begin
                    r_drain   <= 1'b1;
                    r_left    <= n_count;
                    r_ovf_out <= r_ovf || !stored;
                    r_count   <= '0;
                    r_ovf     <= 1'b0;
                end else begin
                    r_count <= n_count;
                    if (!stored) r_ovf <= 1'b1;
                end
            end
        end
    end

    // Emit head of chain while draining; it shifts forward the same edge.
    assign o_strobe    = r_drain;
    assign o_position  = cell_q[0].pos;
    assign o_last_rank = r_drain && (r_left == CntW'(1));
    assign o_overflow  = r_ovf_out;
endmodule

// File: test/tb.sv
// Testbench for row_argsort_core: streams rows of float bit patterns into the core.
// It predicts the sorted positions with a scoreboard class and checks every strobed result.
// Depends on ras_pkg and row_argsort_core.
`timescale 1ns / 1ps

import ras_pkg::*;

// Holds the row being collected and the positions still owed by the core.
class argsort_scoreboard;
    typedef struct {
        logic [PosW-1:0] position;
        logic            last_rank;
        logic            overflow;
    } t_rank;

    logic [ValW-1:0] row_vals[$];
    bit              row_overflow;
    bit              descending;
    t_rank           ranks_due[$];
    int              errors;

    function new();
        row_overflow = 0;
        descending   = 0;
        errors       = 0;
    endfunction

    // Fold -0 onto +0, then flip so that unsigned compare follows the total order.
    function logic [ValW-1:0] sort_key(logic [ValW-1:0] bits);
        logic [ValW-1:0] b;
        b = (bits == 32'h8000_0000) ? '0 : bits;
        return b[31] ? ~b : {1'b1, b[30:0]};
    endfunction

    // Record one accepted input transaction; a row end queues the whole ranking.
    function void note_input(logic [ValW-1:0] bits, logic row_end);
        int              idx[$];
        int              n;
        int              j;
        int              cur;
        logic [ValW-1:0] kc;
        logic [ValW-1:0] kp;
        t_rank           r;
        if (row_vals.size() < RowMaxDefault) row_vals.push_back(bits);
        else row_overflow = 1;
        if (!row_end) return;
        n = row_vals.size();
        // Stable insertion sort: ties keep ascending index in both directions.
        for (int i = 0; i < n; i++) begin
            cur = i;
            kc  = sort_key(row_vals[i]);
            idx.push_back(i);
            j = i;
            while (j > 0) begin
                kp = sort_key(row_vals[idx[j-1]]);
                if (kc == kp || (descending ? kc < kp : kc > kp)) break;
                idx[j] = idx[j-1];
                j--;
            end
            idx[j] = cur;
        end
        for (int i = 0; i < n; i++) begin
            r.position  = PosW'(idx[i]);
            r.last_rank = (i == n - 1);
            r.overflow  = row_overflow;
            ranks_due.push_back(r);
        end
        row_vals.delete();
        row_overflow = 0;
    endfunction

    // Compare one strobed result against the oldest owed rank.
    function void check_result(logic [PosW-1:0] pos, logic last, logic ovf);
        t_rank r;
        if (ranks_due.size() == 0) begin
            $display("%0t: unexpected result: position %0d last %0b overflow %0b",
                     $time, pos, last, ovf);
            errors++;
            return;
        end
        r = ranks_due.pop_front();
        if (pos !== r.position) begin
            $display("%0t: position mismatch: expected %0d actual %0d",
                     $time, r.position, pos);
            errors++;
        end
        if (last !== r.last_rank) begin
            $display("%0t: last_rank mismatch: expected %0b actual %0b",
                     $time, r.last_rank, last);
            errors++;
        end
        if (ovf !== r.overflow) begin
            $display("%0t: overflow mismatch: expected %0b actual %0b",
                     $time, r.overflow, ovf);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int WatchdogLimit = 5000;
    localparam int DrainWait     = 8;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [31:0]     i_value_bits;
    logic            i_row_end;
    logic            i_cfg_we;
    logic            i_sort_order;
    logic            o_strobe;
    logic [PosW-1:0] o_position;
    logic            o_last_rank;
    logic            o_overflow;

    argsort_scoreboard sb;
    int                idle_pct;
    int                items_sent;
    int                quiet_cycles;

    row_argsort_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value_bits(i_value_bits),
        .i_row_end   (i_row_end),
        .i_cfg_we    (i_cfg_we),
        .i_sort_order(i_sort_order),
        .o_strobe    (o_strobe),
        .o_position  (o_position),
        .o_last_rank (o_last_rank),
        .o_overflow  (o_overflow)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Check results and watch for a stalled run; values read here are pre-edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_position, o_last_rank, o_overflow);
        if (o_strobe || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("FAIL row_argsort_core");
            $finish;
        end
    end

    // Drive one input transaction; hold start across back-to-back items.
    task automatic send_value(logic [31:0] bits, logic row_end);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_value_bits <= bits;
        i_row_end    <= row_end;
        do @(posedge i_clk); while (busy);
        sb.note_input(bits, row_end);
        items_sent++;
    endtask

    // Wait until every owed result is out, then let the core settle.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.ranks_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    // Write the sort direction; only call with the core idle.
    task automatic set_order(logic desc);
        wait_idle();
        i_cfg_we     <= 1'b1;
        i_sort_order <= desc;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        sb.descending = desc;
    endtask

    // Pick a value: specials, near-duplicates or raw random bits.
    function automatic logic [31:0] pick_value();
        logic [31:0] specials[10] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                      32'hFF80_0000, 32'h7FC0_0001, 32'hFFC0_0000,
                                      32'h0000_0001, 32'h8000_0001, 32'h7F7F_FFFF,
                                      32'h3F80_0000};
        int r;
        r = $urandom_range(99);
        if (r < 25) return specials[$urandom_range(9)];
        if (r < 45) return {1'($urandom_range(1)), 27'd0, 4'($urandom_range(3))};
        return $urandom;
    endfunction

    task automatic send_row(int len);
        for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
    endtask

    initial begin
        logic [31:0] directed[12] = '{32'h3F80_0000, 32'h8000_0000, 32'hFF80_0000,
                                      32'h0000_0000, 32'h7FC0_0000, 32'hFFC0_0001,
                                      32'hFFFF_FFFF, 32'h7F80_0000, 32'h0000_0001,
                                      32'hBF80_0000, 32'h7FFF_FFFF, 32'h3F80_0000};
        int r;
        sb           = new();
        idle_pct     = 18;
        items_sent   = 0;
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_value_bits = '0;
        i_row_end    = 1'b0;
        i_cfg_we     = 1'b0;
        i_sort_order = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: specials with signed zeros and duplicates, both directions.
        for (int i = 0; i < 12; i++) send_value(directed[i], i == 11);
        set_order(1'b1);
        for (int i = 0; i < 12; i++) send_value(directed[i], i == 11);
        send_value(32'hFFFF_FFFF, 1'b1);   // single-element row
        set_order(1'b0);

        // Random rows in three idling phases; set a random direction now and then.
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 18 : (phase == 1) ? 76 : 0;
            while (items_sent < 130 * (phase + 1)) begin
                r = $urandom_range(99);
                if (r < 70) send_row($urandom_range(1, 8));
                else if (r < 85) send_row($urandom_range(9, 64));
                else send_row($urandom_range(65, 70));   // row too long
                if ($urandom_range(99) < 20) set_order(1'($urandom_range(1)));
            end
        end

        wait_idle();
        if (sb.errors == 0) $display("PASS row_argsort_core");
        else $display("FAIL row_argsort_core");
        $finish;
    end
endmodule

// File: sim.f
rtl/ras_pkg.sv
rtl/ras_cell.sv
rtl/row_argsort_core.sv
test/tb.sv
